>>> sv/sdsh_pkg.sv
package sdsh_pkg;
	localparam int BLOCK_BYTES_DEF = 512;
	localparam int INIT_DUMMY_DEF = 10;

	localparam logic [4:0] PH_IDLE = 5'd0, PH_DUMMY = 5'd1, PH_CMD = 5'd2, PH_POLL = 5'd3,
		PH_TAIL = 5'd4, PH_TOKEN = 5'd5, PH_RDATA = 5'd6, PH_RCRC1 = 5'd7, PH_RCRC2 = 5'd8,
		PH_WTOKEN = 5'd9, PH_WDATA = 5'd10, PH_WCRC1 = 5'd11, PH_WCRC2 = 5'd12,
		PH_WRESP = 5'd13, PH_WBUSY = 5'd14, PH_WEXTRA = 5'd15, PH_STOPTOK = 5'd16,
		PH_SBUSY = 5'd17;

	localparam logic [3:0] CS_GO_IDLE = 4'd0, CS_INIT_A = 4'd1, CS_INIT_B = 4'd2,
		CS_BLOCKLEN = 4'd3, CS_READ = 4'd4, CS_STOP = 4'd5, CS_WRITE = 4'd6,
		CS_ER_START = 4'd7, CS_ER_END = 4'd8, CS_ERASE = 4'd9;

	localparam logic [1:0] OP_INIT = 2'd0, OP_READ = 2'd1, OP_WRITE = 2'd2, OP_ERASE = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0, ST_TIMEOUT = 2'd1, ST_REJECT = 2'd2, ST_CMDERR = 2'd3;
	localparam logic [1:0] REG_CMD_RETRY = 2'd0, REG_TOK_RETRY = 2'd1, REG_INIT_RETRY = 2'd2;

	function automatic logic [7:0] cmd_byte(input logic [3:0] s);
		case (s)
			CS_GO_IDLE: cmd_byte = 8'h40;
			CS_INIT_A, CS_INIT_B: cmd_byte = 8'h41;
			CS_BLOCKLEN: cmd_byte = 8'h50;
			CS_READ: cmd_byte = 8'h52;
			CS_STOP: cmd_byte = 8'h4C;
			CS_WRITE: cmd_byte = 8'h59;
			CS_ER_START: cmd_byte = 8'h60;
			CS_ER_END: cmd_byte = 8'h61;
			CS_ERASE: cmd_byte = 8'h66;
			default: cmd_byte = 8'h40;
		endcase
	endfunction
endpackage

>>> sv/sd_card_spi_host_sequencer_core.sv
// channel | valid    | stall     | payload
// in      | in_valid | in_stall  | mode operation block_address block_count received_byte write_byte
// out     | out_valid| out_stall | transmit_byte chip_select_active fast_clock read_valid read_data
//         |          |           | write_taken done_res status card_response
// cfg     | cfg_we   | -         | cfg_index cfg_data
// One item per cycle while in_stall is low: the whole slot decision is one pass from the
// state registers to the result register. in_stall follows out_stall only while a
// result is held, so a stalled output never blocks the cycle it frees. Reset puts
// all sequencer state to its defaults; no clearing pass.
module sd_card_spi_host_sequencer_core #(
	parameter int INIT_DUMMY_BYTES = sdsh_pkg::INIT_DUMMY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        mode,
	input  logic [1:0]  operation,
	input  logic [22:0] block_address,
	input  logic [23:0] block_count,
	input  logic [7:0]  received_byte,
	input  logic [7:0]  write_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  transmit_byte,
	output logic        chip_select_active,
	output logic        fast_clock,
	output logic        read_valid,
	output logic [7:0]  read_data,
	output logic        write_taken,
	output logic        done_res,
	output logic [1:0]  status,
	output logic [7:0]  card_response,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import sdsh_pkg::*;

	localparam logic [9:0] BLK = 10'(BLOCK_BYTES_DEF - 1);
	localparam logic [9:0] NDUMMY = 10'(INIT_DUMMY_BYTES);

	logic [7:0]  cmd_lim_q, init_lim_q;
	logic [15:0] tok_lim_q;
	logic [4:0]  phase_q, phase_d;
	logic [9:0]  bc_q, bc_d;
	logic [15:0] rc_q, rc_d;
	logic [2:0]  fi_q, fi_d;
	logic [31:0] arg_q, arg_d;
	logic [22:0] cur_q, cur_d;
	logic [23:0] left_q, left_d;
	logic [7:0]  ans_q, ans_d;
	logic        fast_q, fast_d;
	logic [3:0]  step_q, step_d;
	logic [7:0]  tx;
	logic        cs, rv, wt, dn;
	logic [1:0]  st;
	logic [15:0] rc_inc;
	logic [23:0] left_dec;
	logic        take;

	assign in_stall = out_valid & out_stall;
	assign take = in_valid & ~in_stall;
	assign rc_inc = rc_q + 16'd1;
	assign left_dec = left_q - 24'd1;

	always_comb begin
		phase_d = phase_q; bc_d = bc_q; rc_d = rc_q; fi_d = fi_q; arg_d = arg_q;
		cur_d = cur_q; left_d = left_q; ans_d = ans_q; fast_d = fast_q; step_d = step_q;
		tx = 8'hFF; cs = 1'b0; rv = 1'b0; wt = 1'b0; dn = 1'b0; st = ST_OK;
		if (!mode) begin
			if (phase_q == PH_IDLE) begin
				cur_d = block_address;
				left_d = (block_count == 24'd0) ? 24'd1 : block_count;
				fi_d = 3'd0; arg_d = {block_address[22:0], 9'd0}; cs = 1'b1;
				phase_d = PH_CMD;
				case (operation)
					OP_INIT: begin
						fast_d = 1'b0; bc_d = 10'd1; cs = 1'b0; phase_d = PH_DUMMY;
						arg_d = arg_q; fi_d = fi_q;
					end
					OP_READ: step_d = CS_READ;
					OP_WRITE: step_d = CS_WRITE;
					default: step_d = CS_ER_START;
				endcase
				if (operation != OP_INIT) tx = cmd_byte(step_d);
			end
		end else begin
			case (phase_q)
				PH_DUMMY: begin
					if (bc_q < NDUMMY) bc_d = bc_q + 10'd1;
					else begin
						bc_d = 10'd0; step_d = CS_GO_IDLE; arg_d = 32'd0; fi_d = 3'd0;
						tx = cmd_byte(CS_GO_IDLE); cs = 1'b1; phase_d = PH_CMD;
					end
				end
				PH_CMD: begin
					cs = 1'b1;
					if (fi_q < 3'd4) begin
						fi_d = fi_q + 3'd1; tx = arg_q[31:24]; arg_d = {arg_q[23:0], 8'd0};
					end else if (fi_q == 3'd4) begin
						fi_d = 3'd5; tx = 8'h95;
					end else begin
						rc_d = 16'd0; phase_d = PH_POLL;
					end
				end
				PH_POLL: begin
					logic ans, tmo;
					ans = received_byte != 8'hFF;
					rc_d = ans ? rc_q : rc_inc;
					tmo = !ans && rc_inc >= {8'd0, cmd_lim_q};
					if (!ans && !tmo) begin
						cs = 1'b1;
					end else begin
						ans_d = received_byte; phase_d = PH_TAIL;
						case (step_q)
							CS_GO_IDLE, CS_INIT_B: begin
								if (!((step_q == CS_GO_IDLE && received_byte == 8'h01) ||
									(step_q == CS_INIT_B && received_byte == 8'h00))) begin
									bc_d = bc_q + 10'd1;
									if (bc_d >= {2'd0, init_lim_q}) begin
										dn = 1'b1; st = ST_TIMEOUT; phase_d = PH_IDLE;
									end
								end
							end
							CS_BLOCKLEN: begin
								fast_d = 1'b1; dn = 1'b1; phase_d = PH_IDLE;
							end
							CS_READ, CS_WRITE, CS_ER_START, CS_ER_END, CS_ERASE: begin
								if (tmo) begin
									dn = 1'b1; st = ST_TIMEOUT; phase_d = PH_IDLE;
								end else if (received_byte != 8'h00) begin
									dn = 1'b1; st = ST_CMDERR; phase_d = PH_IDLE;
								end else if (step_q == CS_ERASE) begin
									dn = 1'b1; phase_d = PH_IDLE;
								end
							end
							default: ;
						endcase
					end
				end
				PH_TAIL: begin
					cs = 1'b1; phase_d = PH_CMD; fi_d = 3'd0; arg_d = 32'd0;
					case (step_q)
						CS_GO_IDLE: if (ans_q == 8'h01) begin
							bc_d = 10'd0; step_d = CS_INIT_A;
						end
						CS_INIT_A: step_d = CS_INIT_B;
						CS_INIT_B: if (ans_q == 8'h00) begin
							step_d = CS_BLOCKLEN; arg_d = 32'(BLOCK_BYTES_DEF);
						end else step_d = CS_INIT_A;
						CS_READ: begin rc_d = 16'd0; phase_d = PH_TOKEN; end
						CS_WRITE: phase_d = PH_WTOKEN;
						CS_ER_START: begin
							step_d = CS_ER_END;
							arg_d = {23'(cur_q + left_dec[22:0]), 9'd0};
						end
						CS_ER_END: step_d = CS_ERASE;
						default: begin cs = 1'b0; dn = 1'b1; phase_d = PH_IDLE; end
					endcase
					if (phase_d == PH_CMD) tx = cmd_byte(step_d);
					else if (phase_d == PH_WTOKEN) tx = 8'hFC;
				end
				PH_TOKEN, PH_WBUSY, PH_SBUSY: begin
					logic hit;
					hit = (phase_q == PH_TOKEN) ? received_byte == 8'hFE : received_byte == 8'hFF;
					cs = 1'b1;
					if (hit) begin
						case (phase_q)
							PH_TOKEN: begin bc_d = 10'd0; phase_d = PH_RDATA; end
							PH_WBUSY: phase_d = PH_WEXTRA;
							default: begin cs = 1'b0; dn = 1'b1; phase_d = PH_IDLE; end
						endcase
					end else begin
						rc_d = rc_inc;
						if (rc_inc >= tok_lim_q) begin
							cs = 1'b0; dn = 1'b1; st = ST_TIMEOUT; phase_d = PH_IDLE;
						end
					end
				end
				PH_RDATA: begin
					rv = 1'b1; cs = 1'b1; bc_d = bc_q + 10'd1;
					if (bc_q == BLK) phase_d = PH_RCRC1;
				end
				PH_RCRC1: begin cs = 1'b1; phase_d = PH_RCRC2; end
				PH_RCRC2, PH_WEXTRA: begin
					left_d = left_dec; cur_d = cur_q + 23'd1; cs = 1'b1;
					if (phase_q == PH_RCRC2) begin
						if (left_dec != 24'd0) begin rc_d = 16'd0; phase_d = PH_TOKEN; end
						else begin
							step_d = CS_STOP; arg_d = 32'd0; fi_d = 3'd0;
							tx = cmd_byte(CS_STOP); phase_d = PH_CMD;
						end
					end else if (left_dec != 24'd0) begin
						tx = 8'hFC; phase_d = PH_WTOKEN;
					end else begin
						tx = 8'hFD; phase_d = PH_STOPTOK;
					end
				end
				PH_WTOKEN: begin
					bc_d = 10'd1; wt = 1'b1; tx = write_byte; cs = 1'b1; phase_d = PH_WDATA;
				end
				PH_WDATA: begin
					cs = 1'b1;
					if (bc_q <= BLK) begin
						bc_d = bc_q + 10'd1; wt = 1'b1; tx = write_byte;
					end else phase_d = PH_WCRC1;
				end
				PH_WCRC1: begin cs = 1'b1; phase_d = PH_WCRC2; end
				PH_WCRC2: begin cs = 1'b1; phase_d = PH_WRESP; end
				PH_WRESP: begin
					if (received_byte[4:0] != 5'h05) begin
						dn = 1'b1; st = ST_REJECT; phase_d = PH_IDLE;
					end else begin
						rc_d = 16'd0; cs = 1'b1; phase_d = PH_WBUSY;
					end
				end
				PH_STOPTOK: begin rc_d = 16'd0; cs = 1'b1; phase_d = PH_SBUSY; end
				default: phase_d = PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_lim_q <= 8'd255; tok_lim_q <= 16'hFFFF; init_lim_q <= 8'd255;
			phase_q <= PH_IDLE; bc_q <= '0; rc_q <= '0; fi_q <= '0; arg_q <= '0;
			cur_q <= '0; left_q <= '0; ans_q <= 8'hFF; fast_q <= 1'b0; step_q <= CS_GO_IDLE;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_CMD_RETRY: cmd_lim_q <= cfg_data[7:0];
					REG_TOK_RETRY: tok_lim_q <= cfg_data;
					REG_INIT_RETRY: init_lim_q <= cfg_data[7:0];
					default: ;
				endcase
			end
			if (take) begin
				phase_q <= phase_d; bc_q <= bc_d; rc_q <= rc_d; fi_q <= fi_d; arg_q <= arg_d;
				cur_q <= cur_d; left_q <= left_d; ans_q <= ans_d; fast_q <= fast_d;
				step_q <= step_d;
			end
			if (take) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			transmit_byte <= tx; chip_select_active <= cs; fast_clock <= fast_d;
			read_valid <= rv; read_data <= rv ? received_byte : 8'd0; write_taken <= wt;
			done_res <= dn; status <= st; card_response <= ans_d;
		end
	end
endmodule
